// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/hrhs_pkg.sv =====
// ---------------------------------------------------------------------------
// hrhs_pkg
// Shared types and constants of the request head scanner.
// ---------------------------------------------------------------------------
`default_nettype none

package hrhs_pkg;

	localparam int unsigned MAX_LEN_DEF  = 4096;
	localparam int unsigned NAME_MAX_DEF = 16;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_T     = 8'h54;

	localparam logic [1:0] REG_NAME_LOW  = 2'd0;
	localparam logic [1:0] REG_NAME_HIGH = 2'd1;
	localparam logic [1:0] REG_NAME_LEN  = 2'd2;

	// Result of one finished buffer.
	typedef struct packed {
		logic        complete;
		logic        line_ok;
		logic [12:0] method_len;
		logic        is_get;
		logic [11:0] path_start;
		logic [12:0] path_len;
		logic [11:0] version_start;
		logic [12:0] version_len;
		logic        header_found;
		logic [12:0] value_offset;
		logic [12:0] value_len;
	} result_t;

endpackage

`default_nettype wire

// ===== design/hrhs_scan.sv =====
// ---------------------------------------------------------------------------
// hrhs_scan
// Front part: consumes one byte per cycle while step is high, tracks all
// scan state and emits a result at the last byte.
// ---------------------------------------------------------------------------
`default_nettype none

module hrhs_scan #(
	parameter int unsigned MAX_LEN  = hrhs_pkg::MAX_LEN_DEF,
	parameter int unsigned NAME_MAX = hrhs_pkg::NAME_MAX_DEF,
	parameter int unsigned OW       = $clog2(MAX_LEN + 1)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         step,
	input  wire logic [7:0]                   data_byte,
	input  wire logic                         last,
	input  wire logic [NAME_MAX*8-1:0]        name_bytes,
	input  wire logic [4:0]                   name_length,
	output logic                              res_valid,
	output hrhs_pkg::result_t                 res
);

	localparam int unsigned WIN = NAME_MAX + 1;
	localparam logic [OW-1:0] MAX_O = OW'(MAX_LEN);

	typedef enum logic [2:0] {LP_METHOD, LP_PATH, LP_VERSION, LP_DONE, LP_FAIL} lp_t;
	typedef enum logic [1:0] {HP_SEARCH, HP_SKIP, HP_VALUE, HP_DONE} hp_t;

	logic [OW-1:0] off_q;
	logic [7:0]    win_q [WIN];
	logic [2:0]    term_q;
	lp_t           lp_q;
	logic [OW-1:0] sp1_q, sp2_q, cr_q, lf_q;
	logic          lf_seen_q;
	hp_t           hp_q;
	logic [OW-1:0] vs_q, vcr_q, vlf_q;
	logic          vlf_seen_q;
	logic          get_q;

	logic          active;
	logic [4:0]    n;
	logic          match;
	logic [2:0]    term_d;
	lp_t           lp_d;
	logic [OW-1:0] sp1_d, sp2_d, cr_d, lf_d, vs_d, vcr_d, vlf_d, end_d;
	logic          lf_seen_d, vlf_seen_d, get_d;
	hp_t           hp_d;

	assign active = off_q < MAX_O;
	assign n = (name_length > 5'(NAME_MAX)) ? 5'(NAME_MAX) : name_length;

	// Name compare against the window of preceding bytes.
	always_comb begin
		match = 1'b1;
		for (int i = 0; i < NAME_MAX; i++) begin
			if (5'(i) < n && win_q[n - 5'(i) - 5'd1] != name_bytes[i*8 +: 8])
				match = 1'b0;
		end
		if (32'(off_q) > 32'(n) && win_q[n] != hrhs_pkg::CH_CR
				&& win_q[n] != hrhs_pkg::CH_LF)
			match = 1'b0;
	end

	// Next scan state for this byte.
	always_comb begin
		term_d = term_q; lp_d = lp_q; sp1_d = sp1_q; sp2_d = sp2_q;
		cr_d = cr_q; lf_d = lf_q; lf_seen_d = lf_seen_q; hp_d = hp_q;
		vs_d = vs_q; vcr_d = vcr_q; vlf_d = vlf_q; vlf_seen_d = vlf_seen_q;
		get_d = get_q;
		if (active) begin
			if (term_q < 3'd4) begin
				if (data_byte == hrhs_pkg::CH_CR)
					term_d = (term_q == 3'd2) ? 3'd3 : 3'd1;
				else if (data_byte == hrhs_pkg::CH_LF && (term_q == 3'd1 || term_q == 3'd3))
					term_d = term_q + 3'd1;
				else
					term_d = 3'd0;
			end
			if (off_q == OW'(0) && data_byte != hrhs_pkg::CH_G) get_d = 1'b0;
			if (off_q == OW'(1) && data_byte != hrhs_pkg::CH_E) get_d = 1'b0;
			if (off_q == OW'(2) && data_byte != hrhs_pkg::CH_T) get_d = 1'b0;
			unique case (lp_q)
				LP_METHOD: begin
					if (data_byte == hrhs_pkg::CH_SPACE) begin
						if (off_q == OW'(0)) lp_d = LP_FAIL;
						else begin sp1_d = off_q; lp_d = LP_PATH; end
					end
				end
				LP_PATH: begin
					if (data_byte == hrhs_pkg::CH_SPACE) begin
						if (off_q == sp1_q + OW'(1)) lp_d = LP_FAIL;
						else begin sp2_d = off_q; lp_d = LP_VERSION; end
					end
				end
				LP_VERSION: begin
					if (data_byte == hrhs_pkg::CH_CR) begin
						cr_d = off_q; lp_d = LP_DONE;
					end else if (data_byte == hrhs_pkg::CH_LF && !lf_seen_q) begin
						lf_d = off_q; lf_seen_d = 1'b1;
					end
				end
				default: ;
			endcase
			unique case (hp_q)
				HP_SEARCH: begin
					if (data_byte == hrhs_pkg::CH_COLON && 32'(off_q) >= 32'(n) && match) begin
						vs_d = off_q + OW'(1); hp_d = HP_SKIP;
					end
				end
				HP_SKIP, HP_VALUE: begin
					if (hp_q == HP_SKIP && (data_byte == hrhs_pkg::CH_SPACE
							|| data_byte == hrhs_pkg::CH_TAB)) begin
						vs_d = off_q + OW'(1);
					end else begin
						if (hp_q == HP_SKIP) begin vs_d = off_q; hp_d = HP_VALUE; end
						if (data_byte == hrhs_pkg::CH_CR) begin
							vcr_d = off_q; hp_d = HP_DONE;
						end else if (data_byte == hrhs_pkg::CH_LF && !vlf_seen_q) begin
							vlf_d = off_q; vlf_seen_d = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
		end_d = active ? off_q + OW'(1) : off_q;
	end

	// Result assembly at the last byte.
	logic          ok;
	logic [OW-1:0] ve, vstart, hs, he;
	always_comb begin
		res = '0;
		vstart = sp2_d + OW'(1);
		ok = 1'b0;
		ve = vstart;
		if (lp_d == LP_DONE) begin ok = 1'b1; ve = cr_d; end
		else if (lp_d == LP_VERSION && lf_seen_d) begin ok = 1'b1; ve = lf_d; end
		res.complete = (term_d == 3'd4);
		if (ok) begin
			res.line_ok       = 1'b1;
			res.method_len    = 13'(sp1_d);
			res.is_get        = (sp1_d == OW'(3)) && get_d;
			res.path_start    = 12'(sp1_d + OW'(1));
			res.path_len      = 13'(sp2_d - sp1_d - OW'(1));
			res.version_start = 12'(vstart);
			res.version_len   = 13'(ve - vstart);
		end
		hs = vs_d;
		if (hp_d == HP_DONE) he = vcr_d;
		else if (hp_d == HP_VALUE && vlf_seen_d) he = vlf_d;
		else he = end_d;
		if (hs > end_d) hs = end_d;
		if (he < hs) he = hs;
		if (hp_d != HP_SEARCH) begin
			res.header_found = 1'b1;
			res.value_offset = 13'(hs);
			res.value_len    = 13'(he - hs);
		end
	end

	assign res_valid = step && last;

	// Scan state registers; cleared after every report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0; term_q <= '0; lp_q <= LP_METHOD; hp_q <= HP_SEARCH;
			sp1_q <= '0; sp2_q <= '0; cr_q <= '0; lf_q <= '0; lf_seen_q <= 1'b0;
			vs_q <= '0; vcr_q <= '0; vlf_q <= '0; vlf_seen_q <= 1'b0; get_q <= 1'b1;
			for (int k = 0; k < WIN; k++) win_q[k] <= '0;
		end else if (step) begin
			if (last) begin
				off_q <= '0; term_q <= '0; lp_q <= LP_METHOD; hp_q <= HP_SEARCH;
				sp1_q <= '0; sp2_q <= '0; cr_q <= '0; lf_q <= '0; lf_seen_q <= 1'b0;
				vs_q <= '0; vcr_q <= '0; vlf_q <= '0; vlf_seen_q <= 1'b0; get_q <= 1'b1;
				for (int k = 0; k < WIN; k++) win_q[k] <= '0;
			end else begin
				off_q <= end_d; term_q <= term_d; lp_q <= lp_d; hp_q <= hp_d;
				sp1_q <= sp1_d; sp2_q <= sp2_d; cr_q <= cr_d; lf_q <= lf_d;
				lf_seen_q <= lf_seen_d; vs_q <= vs_d; vcr_q <= vcr_d; vlf_q <= vlf_d;
				vlf_seen_q <= vlf_seen_d; get_q <= get_d;
				if (active) begin
					win_q[0] <= data_byte;
					for (int k = 1; k < WIN; k++) win_q[k] <= win_q[k-1];
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/hrhs_queue.sv =====
// ---------------------------------------------------------------------------
// hrhs_queue
// Two-entry result queue between the scanner and the output channel.
// ---------------------------------------------------------------------------
`default_nettype none

module hrhs_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  hrhs_pkg::result_t      push_data,
	output logic                   full,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output hrhs_pkg::result_t      out_data
);

	hrhs_pkg::result_t mem_q [2];
	logic              wp_q, rp_q;
	logic [1:0]        cnt_q;
	logic              pop;

	assign full      = cnt_q == 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_data  = mem_q[rp_q];
	assign pop       = out_valid && !out_stall;

	// Storage for queued results.
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== design/http_request_head_scanner.sv =====
// ---------------------------------------------------------------------------
// http_request_head_scanner
// Byte-serial scanner of an HTTP request head with a header lookup.
// ---------------------------------------------------------------------------
// Usage: feed one buffer byte per transaction on data_byte with last on the
// final byte. A new byte can follow every cycle while in_stall is low. A
// result transaction is written into the output queue when the last byte is
// accepted and is presented on the output channel from there; the scan state
// clears on that byte so the next byte starts a new buffer. Results pass
// through a two-entry queue; in_stall rises whenever that queue is full, so
// one byte per cycle is accepted only while the queue has room.
// Only the first MAX_LEN bytes of a buffer are scanned. Configuration is
// written through cfg_we, cfg_index and cfg_data while idle. Reset clears
// all scan state and sets the name length to one.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module http_request_head_scanner #(
	parameter int unsigned MAX_LEN  = hrhs_pkg::MAX_LEN_DEF,
	parameter int unsigned NAME_MAX = hrhs_pkg::NAME_MAX_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             complete,
	output logic             line_ok,
	output logic [12:0]      method_len,
	output logic             is_get,
	output logic [11:0]      path_start,
	output logic [12:0]      path_len,
	output logic [11:0]      version_start,
	output logic [12:0]      version_len,
	output logic             header_found,
	output logic [12:0]      value_offset,
	output logic [12:0]      value_len
);

	logic [63:0]       name_low_q, name_high_q;
	logic [4:0]        hdr_count_q;
	logic [127:0]      all_name;
	logic              step, res_valid, full;
	hrhs_pkg::result_t res, q_out;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_low_q <= '0; name_high_q <= '0; hdr_count_q <= 5'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hrhs_pkg::REG_NAME_LOW:  name_low_q <= cfg_data;
				hrhs_pkg::REG_NAME_HIGH: name_high_q <= cfg_data;
				hrhs_pkg::REG_NAME_LEN:  hdr_count_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign all_name = {name_high_q, name_low_q};
	assign in_stall = full;
	assign step     = in_valid && !in_stall;

	hrhs_scan #(.MAX_LEN(MAX_LEN), .NAME_MAX(NAME_MAX)) u_scan (
		.clk(clk), .arst_n(arst_n), .step(step), .data_byte(data_byte), .last(last),
		.name_bytes(all_name[NAME_MAX*8-1:0]), .name_length(hdr_count_q),
		.res_valid(res_valid), .res(res)
	);

	hrhs_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(res_valid), .push_data(res), .full(full),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(q_out)
	);

	assign complete      = q_out.complete;
	assign line_ok       = q_out.line_ok;
	assign method_len    = q_out.method_len;
	assign is_get        = q_out.is_get;
	assign path_start    = q_out.path_start;
	assign path_len      = q_out.path_len;
	assign version_start = q_out.version_start;
	assign version_len   = q_out.version_len;
	assign header_found  = q_out.header_found;
	assign value_offset  = q_out.value_offset;
	assign value_len     = q_out.value_len;

	`ASSERT_NEXT(a_last_gives_result, clk, arst_n, step && last, out_valid, "no result after last byte")
	`ASSERT_IMPLY(a_get_len, clk, arst_n, out_valid && is_get, method_len == 13'd3 && line_ok, "GET flag without a three byte method")
	`ASSERT_IMPLY(a_value_empty, clk, arst_n, out_valid && !header_found, value_offset == 13'd0 && value_len == 13'd0, "value fields without header")

endmodule

`default_nettype wire
